// ===== hdl/periodic_wrap_min_image_distance_macros.svh =====
// Assertion macros used by the checker file of the periodic wrap block.
`ifndef PERIODIC_WRAP_MIN_IMAGE_DISTANCE_MACROS_SVH
`define PERIODIC_WRAP_MIN_IMAGE_DISTANCE_MACROS_SVH

// Checked only outside reset.
`define PWMID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PWMID_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/pwmid_pkg.sv =====
// Shared constants and helpers of the periodic wrap / minimum image distance block.
package pwmid_pkg;

    localparam int COORD_BITS_DFLT = 32;
    localparam int CFG_IDX_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_X   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_X   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_Y   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER_Z   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_Z   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_WRAP_MASK = 3'd6;

    // bus widths, rounded up to whole bytes
    function automatic int in_bus_bits(input int c);
        return ((6 * c + 7) / 8) * 8;
    endfunction

    function automatic int out_bus_bits(input int c);
        return ((4 * c + 1 + 7) / 8) * 8;
    endfunction

endpackage

// ===== hdl/periodic_wrap_min_image_distance.sv =====
// Periodic wrap of a point into a box and distance to its nearest periodic image.
//
//  channel   | dir | handshake                    | payload
//  ----------+-----+------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | own x,y,z, other x,y,z
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | wrapped x,y,z, image_distance
//  cfg       | in  | i_cfg_we (no back-pressure)  | i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while the output does not stall. The pipe has 1 input stage,
// COORD_BITS + 1 remainder stages, 6 wrap/image/square/sum stages and COORD_BITS + 2 root
// stages. The per-bit remainder and square root pipelines set its depth.
// Synchronous active-low reset clears the valid bits and the config registers.
// One stall signal freezes the whole pipe when the output holds an untaken result;
// s_axis_tready drops only then, so nothing is lost or repeated.
module periodic_wrap_min_image_distance
    import pwmid_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DFLT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]              i_cfg_idx,
    input  logic [COORD_BITS-1:0]                i_cfg_data,
    // request in
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // own_x, own_y, own_z, other_x, other_y, other_z (low bits first), zero pad
    input  logic [in_bus_bits(COORD_BITS)-1:0]   s_axis_tdata,
    // result out
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // wrapped_x, wrapped_y, wrapped_z, image_distance (low bits first), zero pad
    output logic [out_bus_bits(COORD_BITS)-1:0]  m_axis_tdata
);

    localparam int C     = COORD_BITS;
    localparam int W     = C + 1;        // width of differences
    localparam int DS    = W;            // remainder stages
    localparam int QS    = C + 2;        // root bits / root stages
    localparam int NB    = 2 * QS;       // sum of squares width
    localparam int L     = (W + 1) / 2;  // low half of magnitude
    localparam int H     = W - L;
    localparam int OUT_W = out_bus_bits(COORD_BITS);

    // ---------------- configuration ----------------
    logic signed [C-1:0] r_lo [3];
    logic signed [C-1:0] r_hi [3];
    logic [2:0]          r_mask;
    logic [W-1:0]        r_w  [3];   // box width, registered
    logic [2:0]          r_act;      // axis wraps

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= '0;
                r_hi[a] <= '0;
            end
            r_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOWER_X:   r_lo[0] <= i_cfg_data;
                REG_UPPER_X:   r_hi[0] <= i_cfg_data;
                REG_LOWER_Y:   r_lo[1] <= i_cfg_data;
                REG_UPPER_Y:   r_hi[1] <= i_cfg_data;
                REG_LOWER_Z:   r_lo[2] <= i_cfg_data;
                REG_UPPER_Z:   r_hi[2] <= i_cfg_data;
                REG_WRAP_MASK: r_mask  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_w[a]   <= W'({r_hi[a][C-1], r_hi[a]} - {r_lo[a][C-1], r_lo[a]});
            r_act[a] <= r_mask[a] && (r_lo[a] < r_hi[a]);
        end
    end

    // ---------------- flow control ----------------
    logic en;
    logic r_qv [0:QS];
    assign en            = !r_qv[QS] || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- input stage + remainder pipeline ----------------
    // index 0 is the input stage, 1..DS take one quotient bit each
    logic                r_dv_vld [0:DS];
    logic [C-1:0]        r_dv_rem [0:DS][3];
    logic [W-1:0]        r_dv_num [0:DS][3];
    logic signed [C-1:0] r_dv_me  [0:DS][3];
    logic signed [C-1:0] r_dv_x   [0:DS][3];
    logic                r_dv_bel [0:DS][3];
    logic                r_dv_abv [0:DS][3];

    logic signed [C-1:0] in_me [3];
    logic signed [C-1:0] in_x  [3];
    logic [C-1:0]        n_dv_rem [1:DS][3];
    logic [C:0]          dv_sh    [1:DS][3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            in_me[a] = s_axis_tdata[a*C +: C];
            in_x[a]  = s_axis_tdata[(3+a)*C +: C];
        end
        for (int k = 1; k <= DS; k++) begin
            for (int a = 0; a < 3; a++) begin
                dv_sh[k][a] = {r_dv_rem[k-1][a], r_dv_num[k-1][a][W-1]};
                if (dv_sh[k][a] >= r_w[a]) begin
                    n_dv_rem[k][a] = C'(dv_sh[k][a] - r_w[a]);
                end else begin
                    n_dv_rem[k][a] = C'(dv_sh[k][a]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DS; k++) r_dv_vld[k] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= s_axis_tvalid;
            for (int k = 1; k <= DS; k++) r_dv_vld[k] <= r_dv_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_dv_me[0][a]  <= in_me[a];
                r_dv_x[0][a]   <= in_x[a];
                r_dv_bel[0][a] <= in_x[a] < r_lo[a];
                r_dv_abv[0][a] <= in_x[a] > r_hi[a];
                r_dv_rem[0][a] <= '0;
                // distance past the box edge, always positive where used
                if (in_x[a] < r_lo[a]) begin
                    r_dv_num[0][a] <= W'({r_lo[a][C-1], r_lo[a]} - {in_x[a][C-1], in_x[a]});
                end else begin
                    r_dv_num[0][a] <= W'({in_x[a][C-1], in_x[a]} - {r_hi[a][C-1], r_hi[a]});
                end
            end
            for (int k = 1; k <= DS; k++) begin
                for (int a = 0; a < 3; a++) begin
                    r_dv_rem[k][a] <= n_dv_rem[k][a];
                    r_dv_num[k][a] <= {r_dv_num[k-1][a][W-2:0], 1'b0};
                    r_dv_me[k][a]  <= r_dv_me[k-1][a];
                    r_dv_x[k][a]   <= r_dv_x[k-1][a];
                    r_dv_bel[k][a] <= r_dv_bel[k-1][a];
                    r_dv_abv[k][a] <= r_dv_abv[k-1][a];
                end
            end
        end
    end

    // ---------------- A: wrap ----------------
    logic                r_av, r_bv, r_cv, r_dv, r_ev;
    logic signed [C-1:0] r_a_wr [3], r_b_wr [3], r_c_wr [3], r_d_wr [3], r_e_wr [3];
    logic signed [C-1:0] r_a_me [3];
    logic signed [W-1:0] r_b_d0 [3];
    logic signed [C+1:0] r_b_d1 [3];
    logic [W-1:0]        r_c_m  [3];
    logic [2*L-1:0]      r_d_pll [3];
    logic [L+H-1:0]      r_d_plh [3];
    logic [2*H-1:0]      r_d_phh [3];
    logic [2*W-1:0]      r_e_sq  [3];

    logic signed [C-1:0] n_a_wr [3];
    logic [C-1:0]        rm [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            rm[a]     = r_dv_rem[DS][a];
            n_a_wr[a] = r_dv_x[DS][a];
            if (r_act[a] && r_dv_bel[DS][a]) begin
                n_a_wr[a] = (rm[a] == '0) ? r_lo[a] : C'(r_hi[a] - rm[a]);
            end else if (r_act[a] && r_dv_abv[DS][a]) begin
                n_a_wr[a] = (rm[a] == '0) ? r_hi[a] : C'(r_lo[a] + rm[a]);
            end
        end
    end

    // ---------------- B: both image differences ----------------
    logic signed [W-1:0] n_b_d0 [3];
    logic signed [C+1:0] d0e [3];
    logic signed [C+1:0] wext [3];
    logic signed [C+1:0] n_b_d1 [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_b_d0[a] = W'({r_a_wr[a][C-1], r_a_wr[a]} - {r_a_me[a][C-1], r_a_me[a]});
            d0e[a]    = {n_b_d0[a][W-1], n_b_d0[a]};
            wext[a]   = {1'b0, r_w[a]};
            if (!r_act[a]) begin
                n_b_d1[a] = d0e[a];
            end else if (r_a_wr[a] > r_a_me[a]) begin
                n_b_d1[a] = d0e[a] - wext[a];
            end else begin
                n_b_d1[a] = d0e[a] + wext[a];
            end
        end
    end

    // ---------------- C: nearer image magnitude ----------------
    logic [W-1:0]  a0 [3];
    logic [C+1:0]  a1 [3];
    logic [W-1:0]  n_c_m [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            a0[a] = r_b_d0[a][W-1] ? W'(-r_b_d0[a]) : W'(r_b_d0[a]);
            a1[a] = r_b_d1[a][C+1] ? (C+2)'(-r_b_d1[a]) : (C+2)'(r_b_d1[a]);
            // alternative only when strictly closer
            n_c_m[a] = (a1[a] < {1'b0, a0[a]}) ? a1[a][W-1:0] : a0[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_cv <= 1'b0;
            r_dv <= 1'b0;
            r_ev <= 1'b0;
        end else if (en) begin
            r_av <= r_dv_vld[DS];
            r_bv <= r_av;
            r_cv <= r_bv;
            r_dv <= r_cv;
            r_ev <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                r_a_wr[a]  <= n_a_wr[a];
                r_a_me[a]  <= r_dv_me[DS][a];
                r_b_wr[a]  <= r_a_wr[a];
                r_b_d0[a]  <= n_b_d0[a];
                r_b_d1[a]  <= n_b_d1[a];
                r_c_wr[a]  <= r_b_wr[a];
                r_c_m[a]   <= n_c_m[a];
                // D: partial products of the square
                r_d_wr[a]  <= r_c_wr[a];
                r_d_pll[a] <= r_c_m[a][L-1:0] * r_c_m[a][L-1:0];
                r_d_plh[a] <= r_c_m[a][L-1:0] * r_c_m[a][W-1:L];
                r_d_phh[a] <= r_c_m[a][W-1:L] * r_c_m[a][W-1:L];
                // E: recombine
                r_e_wr[a]  <= r_d_wr[a];
                r_e_sq[a]  <= ((2*W)'(r_d_phh[a]) << (2*L))
                            + ((2*W)'(r_d_plh[a]) << (L+1))
                            + (2*W)'(r_d_pll[a]);
            end
        end
    end

    // ---------------- F + integer square root pipeline ----------------
    // index 0 holds the sum of squares, each later stage settles one root bit
    logic signed [C-1:0] r_q_wr   [0:QS][3];
    logic [NB-1:0]       r_q_s    [0:QS];
    logic [QS:0]         r_q_rem  [0:QS];
    logic [QS-1:0]       r_q_root [0:QS];

    logic [QS+2:0]       q_sh   [1:QS];
    logic [QS+2:0]       q_tr   [1:QS];
    logic [QS:0]         n_q_rem  [1:QS];
    logic [QS-1:0]       n_q_root [1:QS];

    always_comb begin
        for (int k = 1; k <= QS; k++) begin
            q_sh[k] = {r_q_rem[k-1], r_q_s[k-1][NB-1:NB-2]};
            q_tr[k] = (QS+3)'({r_q_root[k-1], 2'b01});
            if (q_sh[k] >= q_tr[k]) begin
                n_q_rem[k]  = (QS+1)'(q_sh[k] - q_tr[k]);
                n_q_root[k] = {r_q_root[k-1][QS-2:0], 1'b1};
            end else begin
                n_q_rem[k]  = (QS+1)'(q_sh[k]);
                n_q_root[k] = {r_q_root[k-1][QS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QS; k++) r_qv[k] <= 1'b0;
        end else if (en) begin
            r_qv[0] <= r_ev;
            for (int k = 1; k <= QS; k++) r_qv[k] <= r_qv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_s[0]    <= NB'(r_e_sq[0]) + NB'(r_e_sq[1]) + NB'(r_e_sq[2]);
            r_q_rem[0]  <= '0;
            r_q_root[0] <= '0;
            for (int a = 0; a < 3; a++) r_q_wr[0][a] <= r_e_wr[a];
            for (int k = 1; k <= QS; k++) begin
                r_q_s[k]    <= {r_q_s[k-1][NB-3:0], 2'b00};
                r_q_rem[k]  <= n_q_rem[k];
                r_q_root[k] <= n_q_root[k];
                for (int a = 0; a < 3; a++) r_q_wr[k][a] <= r_q_wr[k-1][a];
            end
        end
    end

    // ---------------- output ----------------
    assign m_axis_tvalid = r_qv[QS];
    assign m_axis_tdata  = OUT_W'({r_q_root[QS][C:0], r_q_wr[QS][2], r_q_wr[QS][1],
                                   r_q_wr[QS][0]});

endmodule

// ===== hdl/pwmid_chk.sv =====
// Port-level checker for the periodic wrap block, bound to the top level.
`include "periodic_wrap_min_image_distance_macros.svh"
module pwmid_chk
    import pwmid_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DFLT
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [out_bus_bits(COORD_BITS)-1:0] m_axis_tdata
);

    // reset empties the pipe
    `PWMID_ASSERT_ALL(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    // a held result keeps its payload
    `PWMID_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "held result changed")
    // input side stalls exactly when a result is refused
    `PWMID_ASSERT(a_ready, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready mismatch")
    // a refused result blocks new requests for that cycle
    `PWMID_ASSERT(a_block, m_axis_tvalid && !m_axis_tready |-> !(s_axis_tvalid && s_axis_tready), "request taken during stall")

endmodule

bind periodic_wrap_min_image_distance pwmid_chk #(.COORD_BITS(COORD_BITS)) u_pwmid_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/periodic_wrap_min_image_distance_tb.sv =====
// Testbench for the periodic wrap / minimum image distance block: directed table plus random.
`timescale 1ns / 1ps

module periodic_wrap_min_image_distance_tb;
    import pwmid_pkg::*;

    localparam int CB       = 32;
    localparam int IN_BITS  = in_bus_bits(CB);
    localparam int OUT_BITS = out_bus_bits(CB);
    localparam int LATENCY  = 2 * CB + 10;       // pipe depth from the top-level header
    localparam int STALL_LIMIT = 4000;           // base part of the watchdog's limit on cycles with no transfer
    localparam int N_RANDOM = 1230;

    typedef struct packed {
        logic signed [CB-1:0] oz, oy, ox;        // other point
        logic signed [CB-1:0] mz, my, mx;        // own point
    } t_pair;

    typedef struct packed {
        logic [CB:0]          idist;
        logic signed [CB-1:0] wz, wy, wx;
    } t_image;

    typedef struct {
        t_pair  p;
        bit     has_exp;                         // expected value typed in the table
        t_image e;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CB-1:0]        i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_BITS-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_axis_tdata;

    periodic_wrap_min_image_distance #(.COORD_BITS(CB)) dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor copy of the box registers
    logic signed [CB-1:0] box_lo [3];
    logic signed [CB-1:0] box_hi [3];
    logic [2:0]           axis_en;

    t_image images_due[$];
    int     n_bad = 0;
    int     idle_cycles = 0;
    bit     timed_out = 0;
    int     src_idle_pct = 0, snk_idle_pct = 0;
    bit     hold_sink = 0;                       // long receiver hold-off

    function automatic logic [CB:0] root_of(logic [2*CB+2:0] s);
        logic [CB:0]       r;
        logic [CB:0]       c;
        r = '0;
        for (int b = CB; b >= 0; b--) begin
            c = r | ((CB+1)'(1) << b);
            if ({(2*CB+3)'(0), c} * c <= s) r = c;
        end
        return r;
    endfunction

    function automatic t_image image_of(t_pair p);
        t_image r;
        logic signed [CB+1:0] own_c [3], oth_c [3];
        logic signed [CB+1:0] lo, hi, w, x, d, alt, df, me;
        logic [CB+1:0]        m;
        logic [2*CB+2:0]      sum;
        own_c = '{p.mx, p.my, p.mz};
        oth_c = '{p.ox, p.oy, p.oz};
        sum = '0;
        for (int a = 0; a < 3; a++) begin
            me = own_c[a];
            x  = oth_c[a];
            lo = box_lo[a];
            hi = box_hi[a];
            if (axis_en[a] && lo < hi) begin
                w = hi - lo;
                if (x < lo) begin
                    d = (lo - x) % w;
                    x = (d == 0) ? lo : hi - d;
                end else if (x > hi) begin
                    d = (x - hi) % w;
                    x = (d == 0) ? hi : lo + d;
                end
                if (me == x) df = 0;
                else begin
                    alt = (me < x) ? x - w : x + w;
                    df = ((me - alt < 0 ? alt - me : me - alt) <
                          (me - x < 0 ? x - me : me - x)) ? alt - me : x - me;
                end
            end else begin
                df = x - me;
            end
            if (a == 0) r.wx = x[CB-1:0];
            if (a == 1) r.wy = x[CB-1:0];
            if (a == 2) r.wz = x[CB-1:0];
            m = df < 0 ? -df : df;
            sum += {(CB+1)'(0), m} * m;
        end
        r.idist = root_of(sum);
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CB-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_LOWER_X:   box_lo[0] = v;
            REG_UPPER_X:   box_hi[0] = v;
            REG_LOWER_Y:   box_lo[1] = v;
            REG_UPPER_Y:   box_hi[1] = v;
            REG_LOWER_Z:   box_lo[2] = v;
            REG_UPPER_Z:   box_hi[2] = v;
            REG_WRAP_MASK: axis_en = v[2:0];
            default: ;
        endcase
    endtask

    task automatic set_box(logic [CB-1:0] lx, hx, ly, hy, lz, hz, logic [2:0] en);
        // stop offering, drain, then let the pipe empty before touching the box
        s_axis_tvalid <= 1'b0;
        wait (images_due.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
        write_reg(REG_LOWER_X, lx);
        write_reg(REG_UPPER_X, hx);
        write_reg(REG_LOWER_Y, ly);
        write_reg(REG_UPPER_Y, hy);
        write_reg(REG_LOWER_Z, lz);
        write_reg(REG_UPPER_Z, hz);
        write_reg(REG_WRAP_MASK, {{(CB-3){1'b0}}, en});
    endtask

    // one request, with random sender gaps; expectation queued on acceptance.
    // tvalid stays high on return so the next request can follow directly.
    task automatic send_pair(t_pair p, bit has_exp, t_image e);
        t_image want;
        want = has_exp ? e : image_of(p);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'(p);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        images_due.push_back(want);
        @(negedge i_clk);
    endtask

    function automatic logic [CB-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($signed($urandom_range(8000)) - 4000) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pair rnd_pair();
        t_pair p;
        p.mx = rnd_coord(); p.my = rnd_coord(); p.mz = rnd_coord();
        p.ox = rnd_coord(); p.oy = rnd_coord(); p.oz = rnd_coord();
        return p;
    endfunction

    // receiver: random stalls, sample at the rising edge
    always @(negedge i_clk)
        m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);

    always @(posedge i_clk) begin
        t_image got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_image'(m_axis_tdata[4*CB:0]);
            if (images_due.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result %h", got);
            end else begin
                want = images_due.pop_front();
                if (got !== want) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: x %h/%h y %h/%h z %h/%h dist %h/%h (exp/got)",
                                 want.wx, got.wx, want.wy, got.wy, want.wz, got.wz,
                                 want.idist, got.idist);
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT + 200 * LATENCY) begin
            $display("FAIL");
            $finish;
        end
    end

    localparam logic [CB-1:0] ONE  = 32'h0001_0000;
    localparam logic [CB-1:0] MAXC = 32'h7FFF_FFFF;
    localparam logic [CB-1:0] MINC = 32'h8000_0000;

    t_row plain_rows[$];
    t_row box_rows[$];
    t_image none;

    initial begin
        t_pair p;
        none = '0;
        box_lo = '{0, 0, 0};
        box_hi = '{0, 0, 0};
        axis_en = '0;

        // no wrapping after reset: result is the other point and plain distance
        plain_rows.push_back('{'{0,0,0,0,0,0}, 1, '{0,0,0,0}});
        plain_rows.push_back('{'{0,0,ONE,0,0,0}, 1, '{ONE,0,0,ONE}});
        plain_rows.push_back('{'{0,0,MINC,0,0,MAXC}, 1,
                               '{33'h0_FFFF_FFFF, 0, 0, MINC}});
        plain_rows.push_back('{'{MINC,MINC,MINC,MAXC,MAXC,MAXC}, 0, none});
        plain_rows.push_back('{'{MAXC,MAXC,MAXC,MINC,MINC,MINC}, 0, none});
        plain_rows.push_back('{'{32'hFFFF_FFFF,0,5,1,2,3}, 0, none});

        // box [-4, 6] on all axes: below, above, on bounds, exact multiples, ties
        box_rows.push_back('{'{0,0,-14*ONE,0,0,0}, 0, none});        // below, remainder 0
        box_rows.push_back('{'{0,0,-5*ONE,0,0,0}, 0, none});         // below
        box_rows.push_back('{'{0,0,16*ONE,0,0,0}, 0, none});         // above, remainder 0
        box_rows.push_back('{'{0,0,9*ONE,0,0,0}, 0, none});          // above
        box_rows.push_back('{'{-4*ONE,6*ONE,0,-4*ONE,6*ONE,0}, 0, none}); // on bounds
        box_rows.push_back('{'{ONE,ONE,ONE,ONE,ONE,ONE}, 0, none});  // equal
        box_rows.push_back('{'{0,0,5*ONE,0,0,0}, 0, none});          // tie between images
        box_rows.push_back('{'{0,0,-ONE,0,0,5*ONE}, 0, none});
        box_rows.push_back('{'{MAXC,MINC,MAXC,MINC,MAXC,MINC}, 0, none});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        src_idle_pct = 34; snk_idle_pct = 79;
        foreach (plain_rows[i]) send_pair(plain_rows[i].p, plain_rows[i].has_exp,
                                          plain_rows[i].e);

        set_box(-4*ONE, 6*ONE, -4*ONE, 6*ONE, -4*ONE, 6*ONE, 3'b111);
        foreach (box_rows[i]) send_pair(box_rows[i].p, 0, none);

        // widest box, mixed mask, reversed bounds on z
        set_box(MINC, MAXC, -ONE, ONE, 7*ONE, -7*ONE, 3'b101);
        for (int i = 0; i < N_RANDOM / 4; i++) send_pair(rnd_pair(), 0, none);

        // long receiver hold-off while requests keep coming
        src_idle_pct = 0; snk_idle_pct = 0;
        fork
            begin
                hold_sink = 1;
                repeat (3 * LATENCY) @(negedge i_clk);
                hold_sink = 0;
            end
            for (int i = 0; i < N_RANDOM / 4; i++) send_pair(rnd_pair(), 0, none);
        join

        src_idle_pct = 79; snk_idle_pct = 34;
        set_box(-100*ONE, 37*ONE + 5, 3, 4, MINC, MINC + 1, 3'b011);
        for (int i = 0; i < N_RANDOM / 4; i++) send_pair(rnd_pair(), 0, none);

        src_idle_pct = 0; snk_idle_pct = 0;
        set_box($urandom, $urandom, -2*ONE, 2*ONE, MAXC - 9, MAXC, 3'b110);
        for (int i = 0; i < N_RANDOM / 4; i++) send_pair(rnd_pair(), 0, none);

        s_axis_tvalid <= 1'b0;
        wait (images_due.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_bad == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
